// ----- src/pmdfp_pkg.sv -----
// package for the prefix match decimal field parser
// holds the prefix table, character codes, operation codes and default limits
// no dependencies
package pmdfp_pkg;

	localparam int MAX_LINE_LEN_DEF = 15;
	localparam int PREFIX_LEN = 10;
	localparam int PREFIX_IDX_W = 4;
	localparam int BYTE_W = 8;

	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0d;
	localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0a;
	localparam logic [BYTE_W-1:0] CHAR_0 = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_9 = 8'h39;

	typedef enum logic {
		OP_BYTE  = 1'b0,
		OP_REARM = 1'b1
	} op_t;

	// state that does not depend on the line limit
	typedef struct packed {
		logic              done;
		logic [BYTE_W-1:0] acc;
		logic              stopped;
		logic [BYTE_W-1:0] len;
		logic              ovf;
	} flags_t;

	// expected character at each prefix place
	function automatic logic [BYTE_W-1:0] prefix_char(input logic [PREFIX_IDX_W-1:0] idx);
		logic [BYTE_W-1:0] c;
		case (idx)
			4'd0: c = 8'h2b;
			4'd1: c = 8'h4e;
			4'd2: c = 8'h53;
			4'd3: c = 8'h4f;
			4'd4: c = 8'h4e;
			4'd5: c = 8'h4d;
			4'd6: c = 8'h49;
			4'd7: c = 8'h3a;
			4'd8: c = 8'h30;
			4'd9: c = 8'h2c;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- src/pmdfp_cmd_if.sv -----
// request channel into the parser: operation and received byte
// depends on pmdfp_pkg
interface pmdfp_cmd_if;
	logic                 valid;
	logic                 ready;
	pmdfp_pkg::op_t       operation;
	logic [7:0]           rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

// ----- src/pmdfp_rsp_if.sv -----
// result channel out of the parser: completion status and parsed length
// no dependencies
interface pmdfp_rsp_if;
	logic       valid;
	logic       ready;
	logic       complete;
	logic [7:0] data_length;
	logic       overflowed;

	modport source (output valid, output complete, output data_length, output overflowed,
		input ready);
	modport sink (input valid, input complete, input data_length, input overflowed,
		output ready);
endinterface

// ----- src/pmdfp_step.sv -----
// next-state logic for one request: prefix hunt, field count and decimal accumulate
// depends on pmdfp_pkg
module pmdfp_step #(
	parameter int MAX_LINE_LEN = pmdfp_pkg::MAX_LINE_LEN_DEF,
	parameter int POS_W = $clog2(MAX_LINE_LEN + 2)
) (
	input  pmdfp_pkg::op_t   operation,
	input  logic [7:0]       rx_byte,
	input  pmdfp_pkg::flags_t cur,
	input  logic [POS_W-1:0] cur_pos,
	output pmdfp_pkg::flags_t nxt,
	output logic [POS_W-1:0] nxt_pos
);
	import pmdfp_pkg::*;

	localparam logic [POS_W-1:0] PrefixEnd = POS_W'(PREFIX_LEN);
	localparam logic [POS_W-1:0] LineMax = POS_W'(MAX_LINE_LEN);

	logic [POS_W-1:0]  pos_inc;
	logic              is_digit;
	logic              is_eol;
	logic [BYTE_W-1:0] acc_next;

	assign pos_inc = cur_pos + POS_W'(1);
	assign is_digit = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
	assign is_eol = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
	assign acc_next = (cur.acc << 3) + (cur.acc << 1) + (rx_byte - CHAR_0);

	always_comb begin
		nxt = cur;
		nxt_pos = cur_pos;
		if (operation == OP_REARM) begin
			nxt.done = 1'b0;
			nxt.ovf = 1'b0;
			nxt.acc = '0;
			nxt.stopped = 1'b0;
			nxt_pos = '0;
		end else if (!cur.done) begin
			if (cur_pos < PrefixEnd) begin
				if (rx_byte == prefix_char(cur_pos[PREFIX_IDX_W-1:0])) begin
					nxt_pos = pos_inc;
					if (pos_inc == PrefixEnd) begin
						nxt.acc = '0;
						nxt.stopped = 1'b0;
					end
				end else begin
					nxt_pos = '0;
					nxt.acc = '0;
					nxt.stopped = 1'b0;
				end
			end else if (is_eol) begin
				if (cur_pos > PrefixEnd) begin
					nxt.len = cur.acc;
					nxt.ovf = 1'b0;
					nxt.done = 1'b1;
				end
				nxt_pos = '0;
				nxt.acc = '0;
				nxt.stopped = 1'b0;
			end else begin
				if (!cur.stopped && is_digit) begin
					nxt.acc = acc_next;
				end else begin
					nxt.stopped = 1'b1;
				end
				nxt_pos = pos_inc;
				if (pos_inc > LineMax) begin
					nxt.ovf = 1'b1;
					nxt.done = 1'b1;
					nxt_pos = '0;
					nxt.acc = '0;
					nxt.stopped = 1'b0;
				end
			end
		end
	end
endmodule

// ----- src/prefix_match_decimal_field_parser.sv -----
// Prefix match decimal field parser. Each request is either a received byte or a
// rearm; each one gives exactly one result with the status after it: complete,
// the last parsed length (modulo 256) and the overflow flag. A request is taken
// into an input register, its state update is worked out combinationally and lands
// in the result register, so a new request is accepted every cycle while the sink
// takes results. The result register holds a result while the sink stalls, and the
// input register keeps taking a request during that time until it is full.
// depends on pmdfp_pkg, pmdfp_cmd_if, pmdfp_rsp_if and pmdfp_step
module prefix_match_decimal_field_parser #(
	parameter int MAX_LINE_LEN = pmdfp_pkg::MAX_LINE_LEN_DEF
) (
	input logic clk,
	input logic arst_n,
	pmdfp_cmd_if.sink cmd,
	pmdfp_rsp_if.source rsp
);
	import pmdfp_pkg::*;

	localparam int POS_W = $clog2(MAX_LINE_LEN + 2);

	logic             valid_s1;
	op_t              op_s1;
	logic [7:0]       byte_s1;
	logic             rsp_valid_q;
	flags_t           flags_q;
	flags_t           flags_nxt;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_nxt;
	logic             advance;

	assign advance = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1 <= cmd.operation;
			byte_s1 <= cmd.rx_byte;
		end
	end

	pmdfp_step #(
		.MAX_LINE_LEN(MAX_LINE_LEN),
		.POS_W(POS_W)
	) u_step (
		.operation(op_s1),
		.rx_byte(byte_s1),
		.cur(flags_q),
		.cur_pos(pos_q),
		.nxt(flags_nxt),
		.nxt_pos(pos_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			pos_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				flags_q <= flags_nxt;
				pos_q <= pos_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.complete = flags_q.done;
	assign rsp.data_length = flags_q.len;
	assign rsp.overflowed = flags_q.ovf;

`ifndef NO_ASSERTIONS
	// position never passes the line limit
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(MAX_LINE_LEN))
		else $error("position beyond line limit");

	// a held line keeps no position
	a_done_pos: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.done |-> pos_q == '0)
		else $error("position not cleared on completion");

	// overflow only comes with completion
	a_ovf_done: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.ovf |-> flags_q.done)
		else $error("overflow without completion");

	// rearm returns to hunting
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_REARM |=> !flags_q.done && !flags_q.ovf && pos_q == '0)
		else $error("rearm did not restart hunting");

	// a stalled result is not overwritten
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |-> !advance)
		else $error("result overwritten while stalled");
`endif
endmodule

// ----- tb/sv/tb_prefix_match_decimal_field_parser.sv -----
`timescale 1ns / 100ps
// testbench for prefix_match_decimal_field_parser: byte and rearm requests with random idling
// on both channels, checked against a line status predictor held in a small scoreboard class
// depends on pmdfp_pkg, pmdfp_cmd_if, pmdfp_rsp_if and the parser rtl
package pmdfp_tb_pkg;
	import pmdfp_pkg::*;

	localparam int LINE_LIMIT = MAX_LINE_LEN_DEF;
	localparam logic [8*PREFIX_LEN-1:0] HEADER_TEXT = "+NSONMI:0,";

	typedef struct packed {
		logic       complete;
		logic [7:0] data_length;
		logic       overflowed;
	} line_status_t;

	function automatic logic [7:0] header_char(input int idx);
		return HEADER_TEXT[8*(PREFIX_LEN-1-idx) +: 8];
	endfunction

	class length_scoreboard;
		logic         line_done;
		logic [4:0]   place;
		logic [7:0]   running_value;
		logic         value_frozen;
		logic [7:0]   held_length;
		logic         overflow_seen;
		line_status_t status_q[$];
		int           errors;

		function new();
			line_done = 1'b0;
			held_length = '0;
			overflow_seen = 1'b0;
			errors = 0;
			restart_line();
		endfunction

		function void restart_line();
			place = '0;
			running_value = '0;
			value_frozen = 1'b0;
		endfunction

		function void note_request(input op_t op, input logic [7:0] b);
			if (op == OP_REARM) begin
				line_done = 1'b0;
				overflow_seen = 1'b0;
				restart_line();
			end else if (!line_done) begin
				if (place < PREFIX_LEN) begin
					if (b == header_char(place)) begin
						place = place + 5'd1;
						if (place == PREFIX_LEN) begin
							running_value = '0;
							value_frozen = 1'b0;
						end
					end else begin
						restart_line();
					end
				end else if (b == CHAR_CR || b == CHAR_LF) begin
					if (place > PREFIX_LEN) begin
						held_length = running_value;
						overflow_seen = 1'b0;
						line_done = 1'b1;
					end
					restart_line();
				end else begin
					if (!value_frozen && b >= CHAR_0 && b <= CHAR_9)
						running_value = running_value * 8'd10 + (b - CHAR_0);
					else
						value_frozen = 1'b1;
					place = place + 5'd1;
					if (place > LINE_LIMIT) begin
						overflow_seen = 1'b1;
						line_done = 1'b1;
						restart_line();
					end
				end
			end
			status_q.push_back('{line_done, held_length, overflow_seen});
		endfunction

		function void report(input string msg);
			errors++;
			if (errors <= 10)
				$display("%0t mismatch: %s", $realtime, msg);
		endfunction

		function void check_result(input line_status_t got);
			line_status_t want;
			if (status_q.size() == 0) begin
				report($sformatf("unexpected result complete=%0b data_length=%0d overflowed=%0b",
					got.complete, got.data_length, got.overflowed));
				return;
			end
			want = status_q.pop_front();
			if (got.complete !== want.complete || got.data_length !== want.data_length ||
					got.overflowed !== want.overflowed)
				report($sformatf({"expected complete=%0b data_length=%0d overflowed=%0b, ",
					"got complete=%0b data_length=%0d overflowed=%0b"},
					want.complete, want.data_length, want.overflowed,
					got.complete, got.data_length, got.overflowed));
		endfunction

		function void close_out();
			if (status_q.size() != 0)
				report($sformatf("%0d results never arrived", status_q.size()));
		endfunction
	endclass
endpackage

module tb_prefix_match_decimal_field_parser;
	import pmdfp_pkg::*;
	import pmdfp_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;
	int   taken = 0;
	length_scoreboard board;

	pmdfp_cmd_if cmd ();
	pmdfp_rsp_if rsp ();

	prefix_match_decimal_field_parser #(
		.MAX_LINE_LEN(LINE_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.rsp(rsp.source)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	// stretches with no idling on either side
	initial begin
		forever begin
			repeat ($urandom_range(100, 400)) @(posedge clk);
			calm <= ~calm;
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		int run;
		int stall;
		rsp.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			run = $urandom_range(1, 8);
			stall = pick_gap();
			rsp.ready <= 1'b1;
			repeat (run) @(posedge clk);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_result('{rsp.complete, rsp.data_length, rsp.overflowed});
	end

	task automatic send_req(input op_t op, input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.operation <= op;
		cmd.rx_byte <= b;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		taken++;
		board.note_request(op, b);
	endtask

	task automatic send_header(input int break_at, input logic [7:0] wrong);
		for (int i = 0; i < PREFIX_LEN; i++)
			send_req(OP_BYTE, (i == break_at) ? wrong : header_char(i));
	endtask

	task automatic send_random_line();
		int field_len;
		int r;
		logic [7:0] b;
		if ($urandom_range(0, 99) < 15)
			send_header($urandom_range(0, PREFIX_LEN - 1), 8'($urandom()));
		else
			send_header(PREFIX_LEN, 8'h00);
		r = $urandom_range(0, 99);
		field_len = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 5) : $urandom_range(6, 8);
		for (int i = 0; i < field_len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				b = CHAR_0 + 8'($urandom_range(0, 9));
			else
				b = 8'($urandom());
			send_req(OP_BYTE, b);
		end
		if ($urandom_range(0, 9) != 0)
			send_req(OP_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
		if (board.line_done) begin
			if ($urandom_range(0, 1))
				repeat ($urandom_range(1, 3)) send_req(OP_BYTE, 8'($urandom()));
			if ($urandom_range(0, 9) < 8)
				send_req(OP_REARM, 8'($urandom()));
		end
	endtask

	initial begin
		int r;
		board = new();
		cmd.valid <= 1'b0;
		cmd.operation <= OP_BYTE;
		cmd.rx_byte <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, and a mismatch whose byte is not taken as a new start
		send_req(OP_REARM, 8'hff);
		send_req(OP_BYTE, 8'h00);
		send_req(OP_BYTE, 8'hff);
		send_req(OP_BYTE, "+");
		send_header(1, "+");
		// empty field goes back to hunting
		send_header(PREFIX_LEN, 8'h00);
		send_req(OP_BYTE, CHAR_LF);
		// value wraps modulo 256, then bytes are dropped until rearm
		send_header(PREFIX_LEN, 8'h00);
		send_req(OP_BYTE, "9");
		send_req(OP_BYTE, "9");
		send_req(OP_BYTE, "9");
		send_req(OP_BYTE, CHAR_CR);
		send_req(OP_BYTE, "7");
		send_req(OP_REARM, 8'h00);
		// digits stop at the first non-digit
		send_header(PREFIX_LEN, 8'h00);
		send_req(OP_BYTE, "1");
		send_req(OP_BYTE, "x");
		send_req(OP_BYTE, "3");
		send_req(OP_BYTE, CHAR_LF);
		send_req(OP_REARM, 8'h00);
		// line too long
		send_header(PREFIX_LEN, 8'h00);
		repeat (LINE_LIMIT - PREFIX_LEN + 1) send_req(OP_BYTE, "5");
		send_req(OP_REARM, 8'h00);

		taken = 0;
		while (taken < 500) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_random_line();
			end else if (r < 88) begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 3))
						0: send_req(OP_BYTE, CHAR_CR);
						1: send_req(OP_BYTE, "+");
						default: send_req(OP_BYTE, 8'($urandom()));
					endcase
				end
			end else begin
				send_req(OP_REARM, 8'($urandom()));
			end
		end
		cmd.valid <= 1'b0;

		while (board.status_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		board.close_out();
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
